// File: hw/rtl/rtt_pkg.sv
package rtt_pkg;

    // Sizing
    localparam int NUM_TIMERS_DEF = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int FIRE_CNT_W     = $clog2(MAX_RESULTS + 1);

    // Repeat count that never runs down
    localparam logic [15:0] FOREVER_COUNT = 16'hFFFF;

    // Operation codes of an input item
    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_KILL = 2'd1,
        OP_TICK = 2'd2
    } t_op;

    // Event codes of a result item
    typedef enum logic [2:0] {
        EV_SET_OK    = 3'd0,
        EV_DUPLICATE = 3'd1,
        EV_FULL      = 3'd2,
        EV_KILLED    = 3'd3,
        EV_KILL_MISS = 3'd4,
        EV_FIRED     = 3'd5,
        EV_NONE_DUE  = 3'd6
    } t_event;

    // One table entry as held in the RAM
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] period;
        logic [15:0] remaining;
        logic [31:0] last_fire;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Read address source
    typedef enum logic [1:0] {
        RS_PTR = 2'd0,
        RS_UP  = 2'd1,
        RS_DN  = 2'd2
    } t_rsel;

    // Write source
    typedef enum logic [1:0] {
        WS_NONE  = 2'd0,
        WS_SHIFT = 2'd1,
        WS_NEW   = 2'd2,
        WS_BACK  = 2'd3
    } t_wsel;

    // ID source of a pending result
    typedef enum logic [1:0] {
        IDS_ITEM  = 2'd0,
        IDS_ENTRY = 2'd1,
        IDS_ZERO  = 2'd2
    } t_idsrc;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_FIND_END,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_TK_RD,
        S_TK_CHK,
        S_TK_END,
        S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic   accept;
        t_rsel  rsel;
        logic   ptr_inc;
        logic   sptr_used;
        logic   sptr_ptr;
        logic   sptr_dec;
        logic   sptr_inc;
        t_wsel  wsel;
        logic   used_inc;
        logic   used_dec;
        logic   ev_load;
        t_event ev_kind;
        t_idsrc ev_src;
        logic   ev_rm;
        logic   pend_set;
        logic   fire_inc;
        logic   out_load;
        logic   out_last;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       ptr_at_used;
        logic       id_eq;
        logic       id_gt;
        logic       full;
        logic       sptr_at_ptr;
        logic       dn_last;
        logic       due;
        logic       gone;
        logic       fire_last;
        logic       pend;
        logic       out_free;
    } t_stat;

endpackage

// File: hw/rtl/rtt_ram.sv
module rtt_ram
    import rtt_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = NUM_TIMERS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/rtt_ctrl.sv
module rtt_ctrl
    import rtt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_operation,
    output logic       o_in_ready,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        cmd         = '0;
        cmd.rsel    = RS_PTR;
        cmd.wsel    = WS_NONE;
        cmd.ev_kind = EV_SET_OK;
        cmd.ev_src  = IDS_ITEM;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    unique case (i_operation)
                        OP_SET, OP_KILL: n_state = S_FIND_RD;
                        OP_TICK:         n_state = S_TK_RD;
                        default:         n_state = S_IDLE;
                    endcase
                end
            end
            // Walk the sorted table up to the first ID not below the item's
            S_FIND_RD: begin
                n_state = i_stat.ptr_at_used ? S_FIND_END : S_FIND_CHK;
            end
            S_FIND_CHK: begin
                priority if (i_stat.id_eq) begin
                    cmd.ev_load = 1'b1;
                    if (i_stat.op == OP_SET) begin
                        cmd.ev_kind = EV_DUPLICATE;
                        n_state     = S_EMIT;
                    end else begin
                        cmd.ev_kind  = EV_KILLED;
                        cmd.sptr_ptr = 1'b1;
                        n_state      = S_DN_RD;
                    end
                end else if (i_stat.id_gt) begin
                    n_state = S_FIND_END;
                end else begin
                    cmd.ptr_inc = 1'b1;
                    n_state     = S_FIND_RD;
                end
            end
            S_FIND_END: begin
                if (i_stat.op == OP_SET) begin
                    if (i_stat.full) begin
                        cmd.ev_load = 1'b1;
                        cmd.ev_kind = EV_FULL;
                        n_state     = S_EMIT;
                    end else begin
                        cmd.sptr_used = 1'b1;
                        n_state       = S_UP_RD;
                    end
                end else begin
                    cmd.ev_load = 1'b1;
                    cmd.ev_kind = EV_KILL_MISS;
                    n_state     = S_EMIT;
                end
            end
            // Open a gap at the insert position, top entry first
            S_UP_RD: begin
                if (i_stat.sptr_at_ptr) begin
                    cmd.wsel     = WS_NEW;
                    cmd.used_inc = 1'b1;
                    cmd.ev_load  = 1'b1;
                    cmd.ev_kind  = EV_SET_OK;
                    n_state      = S_EMIT;
                end else begin
                    cmd.rsel = RS_UP;
                    n_state  = S_UP_WR;
                end
            end
            S_UP_WR: begin
                cmd.wsel     = WS_SHIFT;
                cmd.sptr_dec = 1'b1;
                n_state      = S_UP_RD;
            end
            // Close the gap of a removed entry
            S_DN_RD: begin
                if (i_stat.dn_last) begin
                    cmd.used_dec = 1'b1;
                    n_state      = S_EMIT;
                end else begin
                    cmd.rsel = RS_DN;
                    n_state  = S_DN_WR;
                end
            end
            S_DN_WR: begin
                cmd.wsel     = WS_SHIFT;
                cmd.sptr_inc = 1'b1;
                n_state      = S_DN_RD;
            end
            // Tick scan in ascending ID order
            S_TK_RD: begin
                n_state = i_stat.ptr_at_used ? S_TK_END : S_TK_CHK;
            end
            S_TK_CHK: begin
                priority if (!i_stat.due) begin
                    cmd.ptr_inc = 1'b1;
                    n_state     = S_TK_RD;
                end else if (i_stat.pend && !i_stat.out_free) begin
                    n_state = S_TK_CHK;
                end else begin
                    // earlier firing goes out now that another follows
                    cmd.out_load = i_stat.pend;
                    cmd.out_last = 1'b0;
                    cmd.ev_load  = 1'b1;
                    cmd.ev_kind  = EV_FIRED;
                    cmd.ev_src   = IDS_ENTRY;
                    cmd.ev_rm    = i_stat.gone;
                    cmd.pend_set = 1'b1;
                    cmd.fire_inc = 1'b1;
                    if (i_stat.gone) begin
                        cmd.sptr_ptr = 1'b1;
                        n_state      = S_DN_RD;
                    end else begin
                        cmd.wsel    = WS_BACK;
                        cmd.ptr_inc = 1'b1;
                        n_state     = i_stat.fire_last ? S_TK_END : S_TK_RD;
                    end
                end
            end
            S_TK_END: begin
                if (!i_stat.pend) begin
                    cmd.ev_load = 1'b1;
                    cmd.ev_kind = EV_NONE_DUE;
                    cmd.ev_src  = IDS_ZERO;
                end
                n_state = S_EMIT;
            end
            // Final result of the item
            S_EMIT: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: hw/rtl/rtt_dpath.sv
module rtt_dpath
    import rtt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_timer_id,
    input  logic [31:0] i_period_ms,
    input  logic [15:0] i_repeat_count,
    input  logic [31:0] i_now_ms,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [2:0]  o_event_kind,
    output logic [15:0] o_fired_id,
    output logic        o_removed,
    output logic        o_last_result,
    input  t_cmd        i_cmd,
    output t_stat       o_stat
);

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);

    // Latched item
    logic [1:0]  r_op;
    logic [15:0] r_id;
    logic [31:0] r_period;
    logic [15:0] r_count;
    logic [31:0] r_now;

    // Scan and shift pointers, fill count
    logic [CW-1:0] r_ptr;
    logic [CW-1:0] r_sptr;
    logic [CW-1:0] r_used;
    logic [FIRE_CNT_W-1:0] r_nfired;

    // Pending result and output register
    logic        r_pend;
    t_event      r_ev_kind;
    logic [15:0] r_ev_id;
    logic        r_ev_rm;
    logic        r_out_valid;
    t_event      r_out_kind;
    logic [15:0] r_out_id;
    logic        r_out_rm;
    logic        r_out_last;

    logic [ENTRY_W-1:0] rdata_raw;
    logic [ENTRY_W-1:0] wdata_raw;
    t_entry             rd;
    t_entry             upd;
    t_entry             fresh;
    logic [CW-1:0]      sptr_m1;
    logic [CW-1:0]      sptr_p1;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;
    logic               we;
    logic [15:0]        new_rem;
    logic [31:0]        elapsed;

    assign rd      = t_entry'(rdata_raw);
    assign sptr_m1 = r_sptr - CW'(1);
    assign sptr_p1 = r_sptr + CW'(1);

    // Fire update: count runs down unless infinite, last fire moves to now
    assign new_rem = (rd.remaining == FOREVER_COUNT) ? rd.remaining : rd.remaining - 16'd1;
    assign elapsed = r_now - rd.last_fire;

    always_comb begin
        upd.id        = rd.id;
        upd.period    = rd.period;
        upd.remaining = new_rem;
        upd.last_fire = r_now;
        fresh.id        = r_id;
        fresh.period    = r_period;
        fresh.remaining = r_count;
        fresh.last_fire = r_now;
    end

    // Read address
    always_comb begin
        unique case (i_cmd.rsel)
            RS_UP:   raddr = sptr_m1[AW-1:0];
            RS_DN:   raddr = sptr_p1[AW-1:0];
            default: raddr = r_ptr[AW-1:0];
        endcase
    end

    // Write port
    always_comb begin
        we    = (i_cmd.wsel != WS_NONE);
        waddr = (i_cmd.wsel == WS_SHIFT) ? r_sptr[AW-1:0] : r_ptr[AW-1:0];
        unique case (i_cmd.wsel)
            WS_NEW:  wdata_raw = fresh;
            WS_BACK: wdata_raw = upd;
            default: wdata_raw = rdata_raw;
        endcase
    end

    rtt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NUM_TIMERS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata_raw),
        .i_raddr(raddr),
        .o_rdata(rdata_raw)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_pend      <= 1'b0;
            r_nfired    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.used_inc) begin
                r_used <= r_used + CW'(1);
            end else if (i_cmd.used_dec) begin
                r_used <= r_used - CW'(1);
            end
            if (i_cmd.accept) begin
                r_pend   <= 1'b0;
                r_nfired <= '0;
            end else begin
                if (i_cmd.pend_set) r_pend <= 1'b1;
                if (i_cmd.fire_inc) r_nfired <= r_nfired + FIRE_CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item, pointers and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_operation;
            r_id     <= i_timer_id;
            r_period <= i_period_ms;
            r_count  <= i_repeat_count;
            r_now    <= i_now_ms;
            r_ptr    <= '0;
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + CW'(1);
        end
        priority if (i_cmd.sptr_used) begin
            r_sptr <= r_used;
        end else if (i_cmd.sptr_ptr) begin
            r_sptr <= r_ptr;
        end else if (i_cmd.sptr_dec) begin
            r_sptr <= sptr_m1;
        end else if (i_cmd.sptr_inc) begin
            r_sptr <= sptr_p1;
        end
        if (i_cmd.ev_load) begin
            r_ev_kind <= i_cmd.ev_kind;
            r_ev_rm   <= i_cmd.ev_rm;
            unique case (i_cmd.ev_src)
                IDS_ENTRY: r_ev_id <= rd.id;
                IDS_ZERO:  r_ev_id <= 16'd0;
                default:   r_ev_id <= r_id;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_kind <= r_ev_kind;
            r_out_id   <= r_ev_id;
            r_out_rm   <= r_ev_rm;
            r_out_last <= i_cmd.out_last;
        end
    end

    // Status
    always_comb begin
        o_stat.op          = r_op;
        o_stat.ptr_at_used = (r_ptr == r_used);
        o_stat.id_eq       = (rd.id == r_id);
        o_stat.id_gt       = (rd.id > r_id);
        o_stat.full        = (r_used == CW'(NUM_TIMERS));
        o_stat.sptr_at_ptr = (r_sptr == r_ptr);
        o_stat.dn_last     = (sptr_p1 == r_used);
        o_stat.due         = (elapsed >= rd.period);
        o_stat.gone        = (new_rem == 16'd0);
        o_stat.fire_last   = (r_nfired == FIRE_CNT_W'(MAX_RESULTS - 1));
        o_stat.pend        = r_pend;
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_kind  = r_out_kind;
    assign o_fired_id    = r_out_id;
    assign o_removed     = r_out_rm;
    assign o_last_result = r_out_last;

endmodule

// File: hw/rtl/repeating_timer_table.sv
// Channel  Handshake                  Payload
// input    i_in_valid / o_in_ready    i_operation i_timer_id i_period_ms i_repeat_count i_now_ms
// output   o_out_valid / i_out_ready  o_event_kind o_fired_id o_removed o_last_result
//
// Entries sit in one RAM sorted by ID with a fill count; each visited entry is read, then
// checked or moved. Set or kill searches the entries below the ID, then shifts the entries
// above it; a duplicate, a full table or a miss ends after the search.
// Tick: scans the live entries in ID order; a sixteenth firing or a removal ends the scan early.
// Reset empties the table at once (fill count cleared); no clearing pass.
// One item at a time; a stalled output holds the scan, the output register frees the input.
module repeating_timer_table
    import rtt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_timer_id,
    input  logic [31:0] i_period_ms,
    input  logic [15:0] i_repeat_count,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_kind,
    output logic [15:0] o_fired_id,
    output logic        o_removed,
    output logic        o_last_result
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    rtt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_operation(i_operation),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Table, pointers and output register
    rtt_dpath #(
        .NUM_TIMERS(NUM_TIMERS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_operation   (i_operation),
        .i_timer_id    (i_timer_id),
        .i_period_ms   (i_period_ms),
        .i_repeat_count(i_repeat_count),
        .i_now_ms      (i_now_ms),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_event_kind  (o_event_kind),
        .o_fired_id    (o_fired_id),
        .o_removed     (o_removed),
        .o_last_result (o_last_result),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );

endmodule

// File: tb/repeating_timer_table_test.sv
module repeating_timer_table_test;
    import rtt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Spare operation code, ignored by the block
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int LONG_HOLD     = 400;
    localparam int PER_PHASE     = 58;
    localparam int TAIL_CYCLES   = 100;
    localparam int SEND_IDLE[4]  = '{0, 55, 0, 27};
    localparam int RECV_STALL[4] = '{0, 0, 55, 27};

    typedef enum logic [1:0] {
        STIM_ITEM,
        STIM_PHASE,
        STIM_HOLD,
        STIM_DRAIN
    } t_stim_kind;

    // One queued item or a control marker for the driver
    typedef struct {
        t_stim_kind  kind;
        logic [1:0]  op;
        logic [15:0] id;
        logic [31:0] period;
        logic [15:0] count;
        logic [31:0] now;
        int          idle_pct;
        int          stall_pct;
    } t_stim;

    typedef struct packed {
        t_event      kind;
        logic [15:0] id;
        logic        removed;
        logic        last;
    } t_report;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        drv_valid = 1'b0;
    logic [1:0]  drv_op = '0;
    logic [15:0] drv_id = '0;
    logic [31:0] drv_period = '0;
    logic [15:0] drv_count = '0;
    logic [31:0] drv_now = '0;
    logic        rcv_ready = 1'b0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_event_kind;
    logic [15:0] o_fired_id;
    logic        o_removed;
    logic        o_last_result;

    // Timer table as the checker sees it
    logic        tbl_valid [NUM_TIMERS_DEF];
    logic [15:0] tbl_id    [NUM_TIMERS_DEF];
    logic [31:0] tbl_period[NUM_TIMERS_DEF];
    logic [15:0] tbl_left  [NUM_TIMERS_DEF];
    logic [31:0] tbl_last  [NUM_TIMERS_DEF];

    t_stim   op_queue[$];
    t_report timer_events_q[$];

    int          fail_count = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_go = 1'b0;
    int          hold_left = 0;
    logic [31:0] clock_ms = 32'd0;

    repeating_timer_table dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (drv_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (drv_op),
        .i_timer_id     (drv_id),
        .i_period_ms    (drv_period),
        .i_repeat_count (drv_count),
        .i_now_ms       (drv_now),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (rcv_ready),
        .o_event_kind   (o_event_kind),
        .o_fired_id     (o_fired_id),
        .o_removed      (o_removed),
        .o_last_result  (o_last_result)
    );

    always #2ns clk = ~clk;

    // Apply one accepted item to the table and queue the events it yields
    function automatic void table_step(input logic [1:0] op, input logic [15:0] id,
                                       input logic [31:0] period, input logic [15:0] count,
                                       input logic [31:0] now);
        t_report     evs[$];
        t_report     ev;
        int          i;
        int          hit;
        int          slot;
        int          best;
        logic [16:0] scan_from;
        logic        gone;

        hit  = -1;
        slot = -1;
        for (i = 0; i < NUM_TIMERS_DEF; i++) begin
            if (tbl_valid[i] && tbl_id[i] == id && hit < 0) hit = i;
            if (!tbl_valid[i] && slot < 0) slot = i;
        end

        case (op)
            OP_SET: begin
                if (hit >= 0) begin
                    evs.push_back('{EV_DUPLICATE, id, 1'b0, 1'b0});
                end else if (slot < 0) begin
                    evs.push_back('{EV_FULL, id, 1'b0, 1'b0});
                end else begin
                    tbl_valid[slot]  = 1'b1;
                    tbl_id[slot]     = id;
                    tbl_period[slot] = period;
                    tbl_left[slot]   = count;
                    tbl_last[slot]   = now;
                    evs.push_back('{EV_SET_OK, id, 1'b0, 1'b0});
                end
            end
            OP_KILL: begin
                if (hit >= 0) begin
                    tbl_valid[hit] = 1'b0;
                    evs.push_back('{EV_KILLED, id, 1'b0, 1'b0});
                end else begin
                    evs.push_back('{EV_KILL_MISS, id, 1'b0, 1'b0});
                end
            end
            OP_TICK: begin
                // walk live timers in ascending ID order
                scan_from = '0;
                while (evs.size() < MAX_RESULTS) begin
                    best = -1;
                    for (i = 0; i < NUM_TIMERS_DEF; i++) begin
                        if (tbl_valid[i] && {1'b0, tbl_id[i]} >= scan_from &&
                            (best < 0 || tbl_id[i] < tbl_id[best]))
                            best = i;
                    end
                    if (best < 0) break;
                    // wrapping elapsed time
                    if (now - tbl_last[best] >= tbl_period[best]) begin
                        if (tbl_left[best] != FOREVER_COUNT)
                            tbl_left[best] = tbl_left[best] - 16'd1;
                        tbl_last[best] = now;
                        gone = (tbl_left[best] == 16'd0);
                        if (gone) tbl_valid[best] = 1'b0;
                        evs.push_back('{EV_FIRED, tbl_id[best], gone, 1'b0});
                        // a removal ends this scan
                        if (gone) break;
                    end
                    scan_from = {1'b0, tbl_id[best]} + 17'd1;
                    if (scan_from > 17'h0FFFF) break;
                end
                if (evs.size() == 0) evs.push_back('{EV_NONE_DUE, 16'd0, 1'b0, 1'b0});
            end
            default: ;
        endcase

        if (evs.size() != 0) begin
            ev = evs.pop_back();
            ev.last = 1'b1;
            evs.push_back(ev);
        end
        foreach (evs[k]) timer_events_q.push_back(evs[k]);
    endfunction

    function automatic void add_item(input logic [1:0] op, input logic [15:0] id,
                                     input logic [31:0] period, input logic [15:0] count,
                                     input logic [31:0] now);
        t_stim s;
        s.kind = STIM_ITEM;
        s.op = op;
        s.id = id;
        s.period = period;
        s.count = count;
        s.now = now;
        s.idle_pct = 0;
        s.stall_pct = 0;
        op_queue.push_back(s);
    endfunction

    function automatic void add_marker(input t_stim_kind kind, input int idle, input int stall);
        t_stim s;
        s.kind = kind;
        s.op = OP_UNUSED;
        s.id = '0;
        s.period = '0;
        s.count = '0;
        s.now = '0;
        s.idle_pct = idle;
        s.stall_pct = stall;
        op_queue.push_back(s);
    endfunction

    // Random item: small ID pool and short periods so timers clash, fire and run out
    function automatic t_stim random_item();
        t_stim s;
        int    r;
        int    k;

        s.kind = STIM_ITEM;
        s.idle_pct = 0;
        s.stall_pct = 0;

        k = $urandom_range(19);
        if ($urandom_range(99) < 85) s.id = (k == 19) ? 16'hFFFF : 16'(k);
        else s.id = 16'($urandom);

        r = $urandom_range(9);
        if (r < 6) s.period = $urandom_range(12);
        else if (r < 8) s.period = 32'd0;
        else if (r == 8) s.period = $urandom;
        else s.period = 32'hFFFF_FFFF;

        r = $urandom_range(19);
        if (r < 8) s.count = 16'($urandom_range(3, 1));
        else if (r < 12) s.count = FOREVER_COUNT;
        else if (r < 15) s.count = 16'd0;
        else if (r < 18) s.count = 16'($urandom);
        else s.count = 16'd1;

        s.now = ($urandom_range(9) == 0) ? $urandom : clock_ms;

        r = $urandom_range(99);
        if (r < 33) begin
            s.op = OP_SET;
        end else if (r < 53) begin
            s.op = OP_KILL;
        end else if (r < 95) begin
            s.op = OP_TICK;
            // occasional jump across the wrap point
            if ($urandom_range(31) == 0) clock_ms = $urandom;
            else clock_ms = clock_ms + 32'($urandom_range(8));
            s.now = clock_ms;
        end else begin
            s.op = OP_UNUSED;
            s.now = $urandom;
        end
        return s;
    endfunction

    // Driver: offers queued items, acts on markers, predicts on acceptance
    always @(posedge clk) begin
        t_stim nxt;
        logic  offer;
        logic  pulse;
        logic  blocked;
        int    next_stall;

        offer = 1'b0;
        pulse = 1'b0;
        blocked = 1'b0;
        next_stall = stall_pct;
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && o_in_ready)
                table_step(drv_op, drv_id, drv_period, drv_count, drv_now);
            if (!drv_valid || o_in_ready) begin
                while (!blocked && op_queue.size() != 0 && op_queue[0].kind != STIM_ITEM) begin
                    case (op_queue[0].kind)
                        STIM_PHASE: begin
                            idle_pct = op_queue[0].idle_pct;
                            next_stall = op_queue[0].stall_pct;
                            void'(op_queue.pop_front());
                        end
                        STIM_HOLD: begin
                            pulse = 1'b1;
                            void'(op_queue.pop_front());
                        end
                        default: begin
                            // pause until every result is back
                            if (timer_events_q.size() == 0) void'(op_queue.pop_front());
                            else blocked = 1'b1;
                        end
                    endcase
                end
                if (!blocked && op_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    nxt = op_queue.pop_front();
                    drv_op <= nxt.op;
                    drv_id <= nxt.id;
                    drv_period <= nxt.period;
                    drv_count <= nxt.count;
                    drv_now <= nxt.now;
                    offer = 1'b1;
                end
                drv_valid <= offer;
            end
            hold_go <= pulse;
            stall_pct <= next_stall;
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_go) begin
            hold_left <= LONG_HOLD;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver ready
    always @(posedge clk) begin
        if (!rst_n) begin
            rcv_ready <= 1'b0;
        end else if (hold_go || hold_left > 1) begin
            rcv_ready <= 1'b0;
        end else begin
            rcv_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Monitor: compare each result item with the oldest predicted event
    always @(posedge clk) begin
        t_report want;
        if (rst_n && o_out_valid && rcv_ready) begin
            if (timer_events_q.size() == 0) begin
                note_failure($sformatf("unexpected item kind %0d id %h removed %b last %b",
                                       o_event_kind, o_fired_id, o_removed, o_last_result));
            end else begin
                want = timer_events_q.pop_front();
                if (o_event_kind !== want.kind || o_fired_id !== want.id ||
                    o_removed !== want.removed || o_last_result !== want.last)
                    note_failure($sformatf(
                        "exp kind %0d id %h removed %b last %b, got kind %0d id %h removed %b last %b",
                        want.kind, want.id, want.removed, want.last,
                        o_event_kind, o_fired_id, o_removed, o_last_result));
            end
        end
    end

    // Stimulus and end of run
    initial begin
        t_stim s;
        int    ph;
        int    counted;
        int    i;

        foreach (tbl_valid[j]) begin
            tbl_valid[j] = 1'b0;
            tbl_id[j] = '0;
            tbl_period[j] = '0;
            tbl_left[j] = '0;
            tbl_last[j] = '0;
        end

        // directed: empty table, extremes, wrap, zero count, full table
        add_marker(STIM_PHASE, 0, 0);
        add_item(OP_TICK, 16'd0, 32'd0, 16'd0, 32'd0);
        add_item(OP_KILL, 16'd0, 32'd0, 16'd0, 32'd0);
        add_item(OP_SET, 16'hFFFF, 32'd0, 16'd2, 32'hFFFF_FFFF);
        add_item(OP_SET, 16'd0, 32'hFFFF_FFFF, FOREVER_COUNT, 32'd0);
        add_item(OP_SET, 16'hFFFF, 32'd7, 16'd1, 32'd3);
        add_item(OP_SET, 16'd5, 32'd10, 16'd0, 32'd100);
        add_item(OP_TICK, 16'd0, 32'd0, 16'd0, 32'd0);
        add_item(OP_TICK, 16'd0, 32'd0, 16'd0, 32'hFFFF_FFFF);
        add_item(OP_KILL, 16'd5, 32'd0, 16'd0, 32'd0);
        add_item(OP_KILL, 16'd5, 32'd0, 16'd0, 32'd0);
        add_item(OP_KILL, 16'd0, 32'd0, 16'd0, 32'd0);
        add_item(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        for (i = 1; i <= NUM_TIMERS_DEF; i++)
            add_item(OP_SET, 16'(i), 32'd0, 16'd2, 32'h5555_5555);
        add_item(OP_SET, 16'h8000, 32'd1, 16'd1, 32'd0);
        add_item(OP_TICK, 16'd0, 32'd0, 16'd0, 32'hAAAA_AAAA);
        add_item(OP_TICK, 16'd0, 32'd0, 16'd0, 32'hAAAA_AAAB);
        add_marker(STIM_DRAIN, 0, 0);

        // random phases with varying idle and stall
        clock_ms = 32'hAAAA_AAAB;
        for (ph = 0; ph < 4; ph++) begin
            add_marker(STIM_PHASE, SEND_IDLE[ph], RECV_STALL[ph]);
            counted = 0;
            while (counted < PER_PHASE) begin
                s = random_item();
                op_queue.push_back(s);
                if (s.op != OP_UNUSED) begin
                    counted++;
                    if (ph == 0 && counted == 20) add_marker(STIM_HOLD, 0, 0);
                    if (ph == 2 && counted == 34) add_marker(STIM_DRAIN, 0, 0);
                end
            end
            add_marker(STIM_DRAIN, 0, 0);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (op_queue.size() != 0 || drv_valid) @(posedge clk);
        while (timer_events_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
